// ===== rtl/melody_tone_sequencer_unit_assert.svh =====
// Assertion macros used by the checker file of the melody tone sequencer.
`ifndef MELODY_TONE_SEQUENCER_UNIT_ASSERT_SVH
`define MELODY_TONE_SEQUENCER_UNIT_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define MTSU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtsu check failed: next-cycle property");

// The consequent must hold in the same cycle as the antecedent.
`define MTSU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtsu check failed: same-cycle property");

`endif

// ===== rtl/mtsu_pkg.sv =====
package mtsu_pkg;

    typedef enum logic [2:0] {
        OP_TONE_TICK   = 3'd0,
        OP_MS_TICK     = 3'd1,
        OP_PLAY_PAUSE  = 3'd2,
        OP_NEXT_SONG   = 3'd3,
        OP_PREV_SONG   = 3'd4,
        OP_STOP        = 3'd5,
        OP_WRITE_ENTRY = 3'd6
    } op_t;

    localparam logic [7:0]  PITCH_COUNT = 8'd36;
    localparam logic [15:0] END_MS      = 16'hFFFF;
    localparam logic [15:0] TONE_TOP    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  note;
        logic [15:0] ms;
    } entry_t;

    // What the entry caches show the player.
    typedef struct packed {
        logic   all_valid;
        logic   busy;
        entry_t cur;
        entry_t nxt;
        entry_t zero;
    } cache_view_t;

    // How the player moves the entry caches along.
    typedef struct packed {
        logic advance;
        logic end_wrap;
        logic rewind;
        logic flush;
        logic wr_en;
    } cache_cmd_t;

    typedef struct packed {
        logic       buzzer;
        logic       playing;
        logic       song_number;
        logic [5:0] note_position;
        logic       tone_active;
    } result_t;

    function automatic logic [15:0] pitch_reload(input logic [5:0] idx);
        logic [15:0] val;
        begin
            case (idx)
                6'd0:    val = 16'd63775;
                6'd1:    val = 16'd63874;
                6'd2:    val = 16'd63967;
                6'd3:    val = 16'd64055;
                6'd4:    val = 16'd64138;
                6'd5:    val = 16'd64217;
                6'd6:    val = 16'd64291;
                6'd7:    val = 16'd64360;
                6'd8:    val = 16'd64426;
                6'd9:    val = 16'd64489;
                6'd10:   val = 16'd64548;
                6'd11:   val = 16'd64603;
                6'd12:   val = 16'd64655;
                6'd13:   val = 16'd64705;
                6'd14:   val = 16'd64751;
                6'd15:   val = 16'd64795;
                6'd16:   val = 16'd64837;
                6'd17:   val = 16'd64876;
                6'd18:   val = 16'd64913;
                6'd19:   val = 16'd64948;
                6'd20:   val = 16'd64981;
                6'd21:   val = 16'd65012;
                6'd22:   val = 16'd65042;
                6'd23:   val = 16'd65069;
                6'd24:   val = 16'd65096;
                6'd25:   val = 16'd65120;
                6'd26:   val = 16'd65144;
                6'd27:   val = 16'd65166;
                6'd28:   val = 16'd65187;
                6'd29:   val = 16'd65206;
                6'd30:   val = 16'd65225;
                6'd31:   val = 16'd65242;
                6'd32:   val = 16'd65259;
                6'd33:   val = 16'd65274;
                6'd34:   val = 16'd65289;
                6'd35:   val = 16'd65303;
                default: val = 16'd0;
            endcase
            return val;
        end
    endfunction

endpackage

// ===== rtl/mtsu_ram.sv =====
module mtsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/mtsu_cache.sv =====
module mtsu_cache
    import mtsu_pkg::*;
#(
    parameter int NUM_SONGS  = 2,
    parameter int SONG_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [((NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1)-1:0] song,
    input  logic [$clog2(SONG_DEPTH)-1:0] ptr,
    input  cache_cmd_t              cmd,
    input  logic                    exec,
    input  logic [((NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1)-1:0] wr_song,
    input  logic [$clog2(SONG_DEPTH)-1:0] wr_idx,
    input  entry_t                  wr_data,
    output cache_view_t             view
);

    localparam int SONG_W = (NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1;
    localparam int PTR_W  = $clog2(SONG_DEPTH);
    localparam int ADDR_W = SONG_W + PTR_W;
    localparam int ENT_W  = $bits(entry_t);

    typedef enum logic [1:0] {
        FILL_CUR,
        FILL_NXT,
        FILL_ZERO
    } fill_tgt_t;

    entry_t      cur_reg, cur_next;
    entry_t      nxt_reg, nxt_next;
    entry_t      zero_reg, zero_next;
    logic        cur_v_reg, cur_v_next;
    logic        nxt_v_reg, nxt_v_next;
    logic        zero_v_reg, zero_v_next;
    logic        busy_reg, busy_next;
    fill_tgt_t   tgt_reg, tgt_next;

    logic [PTR_W-1:0]  ptr_inc;
    logic [ADDR_W-1:0] cur_addr, nxt_addr, zero_addr, wr_addr, rd_addr;
    logic              issue;
    logic [ENT_W-1:0]  rd_data;
    entry_t            fill;

    assign ptr_inc   = (ptr == PTR_W'(SONG_DEPTH - 1)) ? '0 : ptr + 1'b1;
    assign cur_addr  = {song, ptr};
    assign nxt_addr  = {song, ptr_inc};
    assign zero_addr = {song, {PTR_W{1'b0}}};
    assign wr_addr   = {wr_song, wr_idx};
    assign fill      = entry_t'(rd_data);

    // One read is in flight at a time; none is started while an item executes,
    // so the addresses stay put until the data lands.
    assign issue = !busy_reg && !exec && (!cur_v_reg || !nxt_v_reg || !zero_v_reg);

    always_comb
    begin
        if (!cur_v_reg)
        begin
            rd_addr  = cur_addr;
            tgt_next = FILL_CUR;
        end
        else if (!nxt_v_reg)
        begin
            rd_addr  = nxt_addr;
            tgt_next = FILL_NXT;
        end
        else
        begin
            rd_addr  = zero_addr;
            tgt_next = FILL_ZERO;
        end
    end

    mtsu_ram #(
        .WIDTH (ENT_W),
        .DEPTH (2 ** ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        zero_next   = zero_reg;
        cur_v_next  = cur_v_reg;
        nxt_v_next  = nxt_v_reg;
        zero_v_next = zero_v_reg;
        busy_next   = issue;

        if (busy_reg)
        begin
            case (tgt_reg)
                FILL_CUR:
                begin
                    cur_next   = fill;
                    cur_v_next = 1'b1;
                end
                FILL_NXT:
                begin
                    nxt_next   = fill;
                    nxt_v_next = 1'b1;
                end
                FILL_ZERO:
                begin
                    zero_next   = fill;
                    zero_v_next = 1'b1;
                end
                default:
                begin
                    cur_v_next = 1'b0;
                end
            endcase
        end

        if (cmd.advance)
        begin
            cur_next   = cmd.end_wrap ? zero_reg : nxt_reg;
            nxt_v_next = 1'b0;
        end

        if (cmd.rewind)
        begin
            cur_next   = zero_reg;
            nxt_v_next = 1'b0;
        end

        if (cmd.flush)
        begin
            cur_v_next  = 1'b0;
            nxt_v_next  = 1'b0;
            zero_v_next = 1'b0;
        end

        // A write that hits a cached position wins over a fill landing in the
        // same cycle, as the memory now holds the written value.
        if (cmd.wr_en)
        begin
            if (wr_addr == cur_addr)
            begin
                cur_next = wr_data;
            end
            if (wr_addr == nxt_addr)
            begin
                nxt_next = wr_data;
            end
            if (wr_addr == zero_addr)
            begin
                zero_next = wr_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg  <= 1'b0;
            nxt_v_reg  <= 1'b0;
            zero_v_reg <= 1'b0;
            busy_reg   <= 1'b0;
            tgt_reg    <= FILL_CUR;
        end
        else
        begin
            cur_v_reg  <= cur_v_next;
            nxt_v_reg  <= nxt_v_next;
            zero_v_reg <= zero_v_next;
            busy_reg   <= busy_next;
            if (issue)
            begin
                tgt_reg <= tgt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        zero_reg <= zero_next;
    end

    assign view.all_valid = cur_v_reg && nxt_v_reg && zero_v_reg;
    assign view.busy      = busy_reg;
    assign view.cur       = cur_reg;
    assign view.nxt       = nxt_reg;
    assign view.zero      = zero_reg;

endmodule

// ===== rtl/mtsu_player.sv =====
module mtsu_player
    import mtsu_pkg::*;
#(
    parameter int NUM_SONGS  = 2,
    parameter int SONG_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    input  op_t                     op,
    input  logic                    load_song,
    input  logic [5:0]              load_index,
    input  logic [7:0]              load_note,
    input  logic [15:0]             load_ms,
    input  logic                    out_free,
    input  cache_view_t             view,
    output logic                    consume,
    output logic                    exec,
    output cache_cmd_t              cmd,
    output logic [((NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1)-1:0] song,
    output logic [$clog2(SONG_DEPTH)-1:0] ptr,
    output logic [((NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1)-1:0] wr_song,
    output logic [$clog2(SONG_DEPTH)-1:0] wr_idx,
    output entry_t                  wr_data,
    output result_t                 res_next
);

    localparam int SONG_W = (NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1;
    localparam int PTR_W  = $clog2(SONG_DEPTH);
    localparam int EXT_W  = (PTR_W > 6) ? PTR_W : 6;

    logic [SONG_W-1:0] song_reg, song_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic              play_reg, play_next;
    logic [15:0]       cnt_reg, cnt_next;
    logic              ten_reg, ten_next;
    logic              buz_reg, buz_next;
    logic              pend_reg, pend_next;

    logic              ready;
    logic              do_start;
    logic [7:0]        start_sel;
    logic [15:0]       el_inc;
    logic [PTR_W-1:0]  ptr_inc;
    logic              end_hit;
    logic              wr_ok;
    logic [EXT_W-1:0]  idx_ext;
    logic [EXT_W-1:0]  pos_ext;

    assign ready   = view.all_valid && !view.busy;
    assign el_inc  = elapsed_reg + 16'd1;
    assign ptr_inc = (ptr_reg == PTR_W'(SONG_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
    assign end_hit = (view.nxt.ms == END_MS);
    assign idx_ext = EXT_W'(load_index);
    assign wr_ok   = (32'(load_song) < NUM_SONGS) && (32'(load_index) < SONG_DEPTH);

    assign wr_song      = SONG_W'(load_song);
    assign wr_idx       = idx_ext[PTR_W-1:0];
    assign wr_data.note = load_note;
    assign wr_data.ms   = load_ms;
    assign song         = song_reg;
    assign ptr          = ptr_reg;

    always_comb
    begin
        song_next    = song_reg;
        ptr_next     = ptr_reg;
        elapsed_next = elapsed_reg;
        play_next    = play_reg;
        cnt_next     = cnt_reg;
        ten_next     = ten_reg;
        buz_next     = buz_reg;
        pend_next    = pend_reg;
        cmd          = '0;
        consume      = 1'b0;
        exec         = 1'b0;
        do_start     = 1'b0;
        start_sel    = view.cur.note;

        if (item_valid)
        begin
            if (pend_reg)
            begin
                // Second half of a song change: the first entry of the new
                // song is now cached, so its note can start.
                if (ready && out_free)
                begin
                    exec      = 1'b1;
                    consume   = 1'b1;
                    pend_next = 1'b0;
                    do_start  = 1'b1;
                end
            end
            else
            begin
                case (op)
                    OP_WRITE_ENTRY:
                    begin
                        if (out_free)
                        begin
                            exec       = 1'b1;
                            consume    = 1'b1;
                            cmd.wr_en  = wr_ok;
                        end
                    end
                    OP_NEXT_SONG, OP_PREV_SONG:
                    begin
                        if (!view.busy)
                        begin
                            exec         = 1'b1;
                            cmd.flush    = 1'b1;
                            pend_next    = 1'b1;
                            ten_next     = 1'b0;
                            buz_next     = 1'b0;
                            elapsed_next = '0;
                            ptr_next     = '0;
                            play_next    = 1'b1;
                            if (op == OP_NEXT_SONG)
                            begin
                                song_next = (song_reg == SONG_W'(NUM_SONGS - 1)) ?
                                            '0 : song_reg + 1'b1;
                            end
                            else
                            begin
                                song_next = (song_reg == '0) ?
                                            SONG_W'(NUM_SONGS - 1) : song_reg - 1'b1;
                            end
                        end
                    end
                    OP_TONE_TICK:
                    begin
                        if (ready && out_free)
                        begin
                            exec    = 1'b1;
                            consume = 1'b1;
                            if (ten_reg)
                            begin
                                if (cnt_reg == TONE_TOP)
                                begin
                                    if (view.cur.note < PITCH_COUNT)
                                    begin
                                        cnt_next = pitch_reload(view.cur.note[5:0]);
                                        buz_next = !buz_reg;
                                    end
                                    else
                                    begin
                                        ten_next = 1'b0;
                                        buz_next = 1'b0;
                                    end
                                end
                                else
                                begin
                                    cnt_next = cnt_reg + 16'd1;
                                end
                            end
                        end
                    end
                    OP_MS_TICK:
                    begin
                        if (ready && out_free)
                        begin
                            exec    = 1'b1;
                            consume = 1'b1;
                            if (play_reg)
                            begin
                                if (el_inc >= view.cur.ms)
                                begin
                                    elapsed_next = '0;
                                    ptr_next     = end_hit ? '0 : ptr_inc;
                                    cmd.advance  = 1'b1;
                                    cmd.end_wrap = end_hit;
                                    do_start     = 1'b1;
                                    start_sel    = end_hit ? view.zero.note : view.nxt.note;
                                end
                                else
                                begin
                                    elapsed_next = el_inc;
                                end
                            end
                        end
                    end
                    OP_PLAY_PAUSE:
                    begin
                        if (ready && out_free)
                        begin
                            exec    = 1'b1;
                            consume = 1'b1;
                            if (play_reg)
                            begin
                                play_next = 1'b0;
                                ten_next  = 1'b0;
                                buz_next  = 1'b0;
                            end
                            else
                            begin
                                play_next = 1'b1;
                                do_start  = 1'b1;
                            end
                        end
                    end
                    OP_STOP:
                    begin
                        if (ready && out_free)
                        begin
                            exec         = 1'b1;
                            consume      = 1'b1;
                            cmd.rewind   = 1'b1;
                            play_next    = 1'b0;
                            ten_next     = 1'b0;
                            buz_next     = 1'b0;
                            elapsed_next = '0;
                            ptr_next     = '0;
                        end
                    end
                    default:
                    begin
                        if (ready && out_free)
                        begin
                            exec    = 1'b1;
                            consume = 1'b1;
                        end
                    end
                endcase
            end
        end

        // Starting a note: a rest or any value past the table silences the tone.
        if (do_start)
        begin
            if (start_sel < PITCH_COUNT)
            begin
                cnt_next = pitch_reload(start_sel[5:0]);
                ten_next = 1'b1;
            end
            else
            begin
                ten_next = 1'b0;
                buz_next = 1'b0;
            end
        end
    end

    assign pos_ext                = EXT_W'(ptr_next);
    assign res_next.buzzer        = buz_next;
    assign res_next.playing       = play_next;
    assign res_next.song_number   = song_next[0];
    assign res_next.note_position = pos_ext[5:0];
    assign res_next.tone_active   = ten_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            song_reg    <= '0;
            ptr_reg     <= '0;
            elapsed_reg <= '0;
            play_reg    <= 1'b0;
            cnt_reg     <= '0;
            ten_reg     <= 1'b0;
            buz_reg     <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            song_reg    <= song_next;
            ptr_reg     <= ptr_next;
            elapsed_reg <= elapsed_next;
            play_reg    <= play_next;
            cnt_reg     <= cnt_next;
            ten_reg     <= ten_next;
            buz_reg     <= buz_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// ===== rtl/melody_tone_sequencer_unit.sv =====
// The input beat is held in the item register and its result is then registered in the output register.
// Throughput: one beat per cycle while the current, next and first-note caches are full and the output is free.
// A note advance or a stop refills the next-note cache from the song RAM read port.
// A song change refills all three caches through that port.
// Reset clears the player state and empties the caches; the song RAM is not cleared, and
// the caches fill after reset before ticks are taken (writes go at once).
module melody_tone_sequencer_unit
    import mtsu_pkg::*;
#(
    parameter int NUM_SONGS  = 2,
    parameter int SONG_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic        load_song,
    input  logic [5:0]  load_index,
    input  logic [7:0]  load_note,
    input  logic [15:0] load_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        buzzer,
    output logic        playing,
    output logic        song_number,
    output logic [5:0]  note_position,
    output logic        tone_active
);

    localparam int SONG_W = (NUM_SONGS > 1) ? $clog2(NUM_SONGS) : 1;
    localparam int PTR_W  = $clog2(SONG_DEPTH);

    logic        item_valid_reg, item_valid_next;
    logic [2:0]  op_reg;
    logic        song_in_reg;
    logic [5:0]  index_in_reg;
    logic [7:0]  note_in_reg;
    logic [15:0] ms_in_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;

    logic              accept;
    logic              consume;
    logic              exec;
    logic              out_free;
    cache_cmd_t        cmd;
    cache_view_t       view;
    result_t           res_next;
    logic [SONG_W-1:0] song;
    logic [PTR_W-1:0]  ptr;
    logic [SONG_W-1:0] wr_song;
    logic [PTR_W-1:0]  wr_idx;
    entry_t            wr_data;

    assign out_free        = !out_valid_reg || !out_stall;
    assign in_stall        = item_valid_reg && !consume;
    assign accept          = in_valid && !in_stall;
    assign item_valid_next = accept || (item_valid_reg && !consume);
    assign out_valid_next  = consume || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= operation;
            song_in_reg  <= load_song;
            index_in_reg <= load_index;
            note_in_reg  <= load_note;
            ms_in_reg    <= load_ms;
        end
        if (consume)
        begin
            res_reg <= res_next;
        end
    end

    mtsu_player #(
        .NUM_SONGS  (NUM_SONGS),
        .SONG_DEPTH (SONG_DEPTH)
    ) u_player (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid_reg),
        .op         (op_t'(op_reg)),
        .load_song  (song_in_reg),
        .load_index (index_in_reg),
        .load_note  (note_in_reg),
        .load_ms    (ms_in_reg),
        .out_free   (out_free),
        .view       (view),
        .consume    (consume),
        .exec       (exec),
        .cmd        (cmd),
        .song       (song),
        .ptr        (ptr),
        .wr_song    (wr_song),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .res_next   (res_next)
    );

    mtsu_cache #(
        .NUM_SONGS  (NUM_SONGS),
        .SONG_DEPTH (SONG_DEPTH)
    ) u_cache (
        .clk     (clk),
        .rst_n   (rst_n),
        .song    (song),
        .ptr     (ptr),
        .cmd     (cmd),
        .exec    (exec),
        .wr_song (wr_song),
        .wr_idx  (wr_idx),
        .wr_data (wr_data),
        .view    (view)
    );

    assign out_valid     = out_valid_reg;
    assign buzzer        = res_reg.buzzer;
    assign playing       = res_reg.playing;
    assign song_number   = res_reg.song_number;
    assign note_position = res_reg.note_position;
    assign tone_active   = res_reg.tone_active;

endmodule

// ===== rtl/mtsu_checker.sv =====
`include "melody_tone_sequencer_unit_assert.svh"

module mtsu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  operation,
    input  logic        load_song,
    input  logic [5:0]  load_index,
    input  logic [7:0]  load_note,
    input  logic [15:0] load_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        buzzer,
    input  logic        playing,
    input  logic        song_number,
    input  logic [5:0]  note_position,
    input  logic        tone_active
);

    logic [33:0] in_word;
    logic [9:0]  out_word;

    assign in_word  = {operation, load_song, load_index, load_note, load_ms};
    assign out_word = {buzzer, playing, song_number, note_position, tone_active};

    // A stalled input beat stays offered and unchanged.
    `MTSU_ASSERT_NEXT(a_in_stable, in_valid && in_stall, in_valid && $stable(in_word))

    // A stalled result beat stays offered and unchanged.
    `MTSU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `MTSU_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word))

    // The buzzer is only ever high while the tone is running.
    `MTSU_ASSERT_NOW(a_buzz_needs_tone, out_valid && buzzer, tone_active)

    // Pausing or stopping always silences the tone.
    `MTSU_ASSERT_NOW(a_idle_is_silent, out_valid && !playing, !tone_active)

endmodule

bind melody_tone_sequencer_unit mtsu_checker u_mtsu_checker (.*);
